>>> hdl/assert_macros.svh
// assertion macros for the divergence unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define DGD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("dgd assertion failed");
`define DGD_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("dgd assertion failed");
`else
`define DGD_ASSERT(lbl, prop)
`define DGD_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

>>> hdl/dgd_pkg.sv
`timescale 1ns / 1ps
package dgd_pkg;

  localparam int MAX_NODES = 4;
  localparam int MAX_VARS  = 4;
  localparam int FRAC_BITS = 24;

  localparam int NN      = MAX_NODES * MAX_NODES;
  localparam int VN      = MAX_VARS * NN;
  localparam int COEF_D  = 2 * MAX_VARS * MAX_VARS * NN;
  localparam int FLUX_D  = 2 * VN;
  localparam int DA_W    = $clog2(NN);
  localparam int NA_W    = $clog2(VN);
  localparam int CA_W    = $clog2(COEF_D);
  localparam int FA_W    = $clog2(FLUX_D);
  localparam int QDEPTH  = 4;
  localparam int QP_W    = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    OP_LD_DERIV  = 2'd0,
    OP_LD_COEF   = 2'd1,
    OP_LD_SAMPLE = 2'd2,
    OP_COMPUTE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    REG_DIMENSION = 2'd0,
    REG_NUM_NODES = 2'd1,
    REG_NUM_VARS  = 2'd2
  } reg_e;

  typedef struct packed {
    op_e                op;
    logic               comp;
    logic [1:0]         vin;
    logic [1:0]         vout;
    logic [1:0]         ni;
    logic [1:0]         nj;
    logic signed [31:0] value;
    logic signed [31:0] prior;
  } cmd_t;

  typedef struct packed {
    logic [1:0] dimension;
    logic [2:0] num_nodes;
    logic [2:0] num_vars;
  } cfg_t;

  function automatic logic [DA_W-1:0] deriv_addr(logic [1:0] r, logic [1:0] c);
    int a;
    a = int'(r) * MAX_NODES + int'(c);
    return DA_W'(a);
  endfunction

  function automatic logic [NA_W-1:0] node_addr(logic [1:0] v, logic [1:0] i,
                                                 logic [1:0] j);
    int a;
    a = int'(v) * NN + int'(i) * MAX_NODES + int'(j);
    return NA_W'(a);
  endfunction

  function automatic logic [FA_W-1:0] flux_addr(logic s, logic [1:0] v,
                                                 logic [1:0] i, logic [1:0] j);
    int a;
    a = int'(s) * VN + int'(v) * NN + int'(i) * MAX_NODES + int'(j);
    return FA_W'(a);
  endfunction

  function automatic logic [CA_W-1:0] coef_addr(logic s, logic [1:0] c, logic [1:0] d,
                                                 logic [1:0] i, logic [1:0] j);
    int a;
    a = ((int'(s) * MAX_VARS + int'(c)) * MAX_VARS + int'(d)) * NN
        + int'(i) * MAX_NODES + int'(j);
    return CA_W'(a);
  endfunction

  function automatic logic signed [31:0] qadd(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) return s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    return s[31:0];
  endfunction

  function automatic logic signed [31:0] qround(logic signed [63:0] p);
    logic signed [64:0] r;
    logic signed [64:0] sh;
    r  = {p[63], p} + (65'sd1 <<< (FRAC_BITS - 1));
    sh = r >>> FRAC_BITS;
    if ((sh[64:31] == '0) || (sh[64:31] == '1)) return sh[31:0];
    return sh[64] ? 32'sh8000_0000 : 32'sh7fff_ffff;
  endfunction

endpackage

>>> hdl/dgd_front.sv
`timescale 1ns / 1ps
module dgd_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         opcode_i,
  input  logic               component_i,
  input  logic [1:0]         var_in_i,
  input  logic [1:0]         var_out_i,
  input  logic [1:0]         node_i_i,
  input  logic [1:0]         node_j_i,
  input  logic signed [31:0] value_i,
  input  logic signed [31:0] prior_value_i,
  output logic               deq_valid_o,
  input  logic               deq_ready_i,
  output dgd_pkg::cmd_t      deq_cmd_o
);

  dgd_pkg::cmd_t                 queue_q [dgd_pkg::QDEPTH];
  logic [dgd_pkg::QP_W-1:0]      wr_ptr_q, rd_ptr_q;
  logic [dgd_pkg::QP_W:0]        count_q;
  logic                          push, pop;
  dgd_pkg::cmd_t                 cmd;

  assign in_ready_o  = (count_q != (dgd_pkg::QP_W+1)'(dgd_pkg::QDEPTH));
  assign deq_valid_o = (count_q != '0);
  assign push        = in_valid_i && in_ready_o;
  assign pop         = deq_valid_o && deq_ready_i;
  assign deq_cmd_o   = queue_q[rd_ptr_q];

  always_comb begin
    cmd.op    = dgd_pkg::op_e'(opcode_i);
    cmd.comp  = component_i;
    cmd.vin   = var_in_i;
    cmd.vout  = var_out_i;
    cmd.ni    = node_i_i;
    cmd.nj    = node_j_i;
    cmd.value = value_i;
    cmd.prior = prior_value_i;
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push && !pop) count_q <= count_q + 1'b1;
      else if (pop && !push) count_q <= count_q - 1'b1;
    end
  end

endmodule

>>> hdl/dgd_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dgd_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dgd_pkg::cfg_t      cfg_i,
  input  logic               deq_valid_i,
  output logic               deq_ready_o,
  input  dgd_pkg::cmd_t      deq_cmd_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         out_node_i_o,
  output logic [1:0]         out_node_j_o,
  output logic [1:0]         out_var_o,
  output logic signed [31:0] result_value_o,
  output logic               last_o
);

  typedef enum logic [2:0] {S_IDLE, S_FLUX, S_DRAIN, S_OUT, S_DONE} state_e;
  state_e state_q;

  logic signed [31:0] deriv_mem [dgd_pkg::NN];
  logic signed [31:0] coef_mem  [dgd_pkg::COEF_D];
  logic signed [31:0] samp_mem  [dgd_pkg::VN];
  logic signed [31:0] prior_mem [dgd_pkg::VN];
  logic signed [31:0] flux_mem  [dgd_pkg::FLUX_D];

  logic [1:0] k_q, d_q, i_q, j_q;
  logic       t_q;
  logic [2:0] nn, nv;
  logic       two, cfg_ok;
  logic       k_lf, k_lo, t_l, d_l, i_l, j_l;
  logic       adv, pipe_empty, pop, fwr_en;

  logic                        v0_q, sel0_q, first0_q, last0_q, olast0_q;
  logic [dgd_pkg::CA_W-1:0]    ca0_q;
  logic [dgd_pkg::NA_W-1:0]    sa0_q, pa0_q;
  logic [dgd_pkg::DA_W-1:0]    da0_q;
  logic [dgd_pkg::FA_W-1:0]    fa0_q, fwa0_q;
  logic [1:0]                  oi0_q, oj0_q, od0_q;

  logic                        v1_q, sel1_q, first1_q, last1_q, olast1_q;
  logic signed [31:0]          coef_rd_q, deriv_rd_q, samp_rd_q, flux_rd_q, prior1_q;
  logic [dgd_pkg::FA_W-1:0]    fwa1_q;
  logic [1:0]                  oi1_q, oj1_q, od1_q;

  logic                        v2_q, sel2_q, first2_q, last2_q, olast2_q;
  logic signed [63:0]          prod_q;
  logic signed [31:0]          prior2_q;
  logic [dgd_pkg::FA_W-1:0]    fwa2_q;
  logic [1:0]                  oi2_q, oj2_q, od2_q;

  logic                        v3_q, olast3_q;
  logic signed [31:0]          acc_q, acc_nxt, mterm, fin3_q, prior3_q;
  logic [1:0]                  oi3_q, oj3_q, od3_q;

  logic                        out_vld_q;

  assign nn = (cfg_i.num_nodes > 3'(dgd_pkg::MAX_NODES)) ? 3'(dgd_pkg::MAX_NODES)
                                                        : cfg_i.num_nodes;
  assign nv = (cfg_i.num_vars > 3'(dgd_pkg::MAX_VARS)) ? 3'(dgd_pkg::MAX_VARS)
                                                      : cfg_i.num_vars;
  assign two    = (cfg_i.dimension == 2'd2);
  assign cfg_ok = ((cfg_i.dimension == 2'd1) || two) && (nn != '0) && (nv != '0);

  assign k_lf = ({1'b0, k_q} == nv - 3'd1);
  assign k_lo = ({1'b0, k_q} == nn - 3'd1);
  assign t_l  = !two || t_q;
  assign d_l  = ({1'b0, d_q} == nv - 3'd1);
  assign i_l  = ({1'b0, i_q} == nn - 3'd1);
  assign j_l  = !two || ({1'b0, j_q} == nn - 3'd1);

  assign adv         = !out_vld_q || out_ready_i;
  assign pipe_empty  = !(v0_q || v1_q || v2_q || v3_q);
  assign deq_ready_o = (state_q == S_IDLE);
  assign pop         = deq_valid_i && deq_ready_o;

  // sequencer and issue stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      v0_q    <= 1'b0;
      k_q     <= '0;
      t_q     <= 1'b0;
      d_q     <= '0;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (pop && (deq_cmd_i.op == dgd_pkg::OP_COMPUTE) && cfg_ok) begin
            state_q <= S_FLUX;
            k_q <= '0; t_q <= 1'b0; d_q <= '0; i_q <= '0; j_q <= '0;
          end
        end
        S_FLUX: begin
          if (adv) begin
            v0_q     <= 1'b1;
            sel0_q   <= 1'b0;
            ca0_q    <= dgd_pkg::coef_addr(t_q, k_q, d_q, i_q, j_q);
            sa0_q    <= dgd_pkg::node_addr(k_q, i_q, j_q);
            fwa0_q   <= dgd_pkg::flux_addr(t_q, d_q, i_q, j_q);
            first0_q <= (k_q == '0);
            last0_q  <= k_lf;
            if (k_lf) begin
              k_q <= '0;
              if (t_l) begin
                t_q <= 1'b0;
                if (d_l) begin
                  d_q <= '0;
                  if (i_l) begin
                    i_q <= '0;
                    if (j_l) begin
                      j_q     <= '0;
                      state_q <= S_DRAIN;
                    end else j_q <= j_q + 1'b1;
                  end else i_q <= i_q + 1'b1;
                end else d_q <= d_q + 1'b1;
              end else t_q <= 1'b1;
            end else k_q <= k_q + 1'b1;
          end
        end
        S_DRAIN: begin
          if (adv) v0_q <= 1'b0;
          if (pipe_empty) state_q <= S_OUT;
        end
        S_OUT: begin
          if (adv) begin
            v0_q     <= 1'b1;
            sel0_q   <= 1'b1;
            da0_q    <= t_q ? dgd_pkg::deriv_addr(k_q, j_q) : dgd_pkg::deriv_addr(k_q, i_q);
            fa0_q    <= t_q ? dgd_pkg::flux_addr(1'b1, d_q, i_q, k_q)
                            : dgd_pkg::flux_addr(1'b0, d_q, k_q, j_q);
            pa0_q    <= dgd_pkg::node_addr(d_q, i_q, j_q);
            first0_q <= (k_q == '0) && !t_q;
            last0_q  <= k_lo && t_l;
            oi0_q    <= i_q;
            oj0_q    <= j_q;
            od0_q    <= d_q;
            olast0_q <= d_l && i_l && j_l;
            if (t_l) begin
              t_q <= 1'b0;
              if (k_lo) begin
                k_q <= '0;
                if (d_l) begin
                  d_q <= '0;
                  if (i_l) begin
                    i_q <= '0;
                    if (j_l) begin
                      j_q     <= '0;
                      state_q <= S_DONE;
                    end else j_q <= j_q + 1'b1;
                  end else i_q <= i_q + 1'b1;
                end else d_q <= d_q + 1'b1;
              end else k_q <= k_q + 1'b1;
            end else t_q <= 1'b1;
          end
        end
        S_DONE: begin
          if (adv) v0_q <= 1'b0;
          if (pipe_empty) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // stores: load writes and registered reads
  always_ff @(posedge clk_i) begin
    if (pop && (deq_cmd_i.op == dgd_pkg::OP_LD_DERIV) &&
        (int'(deq_cmd_i.ni) < dgd_pkg::MAX_NODES) && (int'(deq_cmd_i.nj) < dgd_pkg::MAX_NODES)) begin
      deriv_mem[dgd_pkg::deriv_addr(deq_cmd_i.ni, deq_cmd_i.nj)] <= deq_cmd_i.value;
    end
    if (adv) deriv_rd_q <= deriv_mem[da0_q];
  end

  always_ff @(posedge clk_i) begin
    if (pop && (deq_cmd_i.op == dgd_pkg::OP_LD_COEF) &&
        (int'(deq_cmd_i.vin) < dgd_pkg::MAX_VARS) && (int'(deq_cmd_i.vout) < dgd_pkg::MAX_VARS) &&
        (int'(deq_cmd_i.ni) < dgd_pkg::MAX_NODES) && (int'(deq_cmd_i.nj) < dgd_pkg::MAX_NODES)) begin
      coef_mem[dgd_pkg::coef_addr(deq_cmd_i.comp, deq_cmd_i.vin, deq_cmd_i.vout,
                                  deq_cmd_i.ni, deq_cmd_i.nj)] <= deq_cmd_i.value;
    end
    if (adv) coef_rd_q <= coef_mem[ca0_q];
  end

  logic ld_samp;
  assign ld_samp = pop && (deq_cmd_i.op == dgd_pkg::OP_LD_SAMPLE) &&
                   (int'(deq_cmd_i.vin) < dgd_pkg::MAX_VARS) &&
                   (int'(deq_cmd_i.ni) < dgd_pkg::MAX_NODES) &&
                   (int'(deq_cmd_i.nj) < dgd_pkg::MAX_NODES);

  always_ff @(posedge clk_i) begin
    if (ld_samp) begin
      samp_mem[dgd_pkg::node_addr(deq_cmd_i.vin, deq_cmd_i.ni, deq_cmd_i.nj)] <= deq_cmd_i.value;
    end
    if (adv) samp_rd_q <= samp_mem[sa0_q];
  end

  always_ff @(posedge clk_i) begin
    if (ld_samp) begin
      prior_mem[dgd_pkg::node_addr(deq_cmd_i.vin, deq_cmd_i.ni, deq_cmd_i.nj)] <= deq_cmd_i.prior;
    end
    if (adv) prior1_q <= prior_mem[pa0_q];
  end

  assign fwr_en = adv && v2_q && last2_q && !sel2_q;

  always_ff @(posedge clk_i) begin
    if (fwr_en) flux_mem[fwa2_q] <= acc_nxt;
    if (adv) flux_rd_q <= flux_mem[fa0_q];
  end

  // multiply, round and accumulate
  assign mterm   = dgd_pkg::qround(prod_q);
  assign acc_nxt = first2_q ? mterm : dgd_pkg::qadd(acc_q, mterm);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      v1_q      <= v0_q;
      v2_q      <= v1_q;
      v3_q      <= v2_q && last2_q && sel2_q;
      out_vld_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sel1_q   <= sel0_q;   first1_q <= first0_q; last1_q <= last0_q;
      olast1_q <= olast0_q; fwa1_q   <= fwa0_q;
      oi1_q    <= oi0_q;    oj1_q    <= oj0_q;    od1_q   <= od0_q;

      prod_q   <= sel1_q ? (64'(deriv_rd_q) * 64'(flux_rd_q))
                         : (64'(coef_rd_q) * 64'(samp_rd_q));
      sel2_q   <= sel1_q;   first2_q <= first1_q; last2_q <= last1_q;
      olast2_q <= olast1_q; fwa2_q   <= fwa1_q;   prior2_q <= prior1_q;
      oi2_q    <= oi1_q;    oj2_q    <= oj1_q;    od2_q   <= od1_q;

      if (v2_q) acc_q <= acc_nxt;
      fin3_q   <= acc_nxt;
      prior3_q <= prior2_q;
      olast3_q <= olast2_q;
      oi3_q    <= oi2_q;    oj3_q    <= oj2_q;    od3_q   <= od2_q;

      result_value_o <= dgd_pkg::qadd(prior3_q, fin3_q);
      out_node_i_o   <= oi3_q;
      out_node_j_o   <= oj3_q;
      out_var_o      <= od3_q;
      last_o         <= olast3_q;
    end
  end

  assign out_valid_o = out_vld_q;

  `DGD_ASSERT(idle_pipe_empty, (state_q == S_IDLE) |-> !(v1_q || v2_q || v3_q))
  `DGD_ASSERT(flux_wr_phase, fwr_en |-> (state_q == S_FLUX || state_q == S_DRAIN))
  `DGD_ASSERT_NEXT(out_after_drain, (state_q == S_DRAIN) && pipe_empty, state_q == S_OUT)

endmodule

>>> hdl/dg_collocated_divergence_apply_unit.sv
`timescale 1ns / 1ps
// channel  | direction | handshake               | payload
// in       | input     | in_valid_i / in_ready_o | opcode, indices, value, prior_value
// cfg      | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
// out      | output    | out_valid_o/out_ready_i | node indices, var, result_value, last
// a load is written to its store in the back end when it is dequeued
// a compute runs a flux pass and an output pass on the single multiply-accumulate
// pipeline, which drains empty between the flux and output passes
// reset clears the queue, the sequencer and the valid flags; stores are undefined
// an output stall freezes the whole back pipeline; the front queue accepts until full
module dg_collocated_divergence_apply_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         opcode_i,
  input  logic               component_i,
  input  logic [1:0]         var_in_i,
  input  logic [1:0]         var_out_i,
  input  logic [1:0]         node_i_i,
  input  logic [1:0]         node_j_i,
  input  logic signed [31:0] value_i,
  input  logic signed [31:0] prior_value_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         out_node_i_o,
  output logic [1:0]         out_node_j_o,
  output logic [1:0]         out_var_o,
  output logic signed [31:0] result_value_o,
  output logic               last_o
);

  dgd_pkg::cfg_t cfg_q;
  dgd_pkg::cmd_t deq_cmd;
  logic          deq_valid, deq_ready;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dimension <= 2'd2;
      cfg_q.num_nodes <= 3'd4;
      cfg_q.num_vars  <= 3'd4;
    end else if (cfg_valid_i) begin
      case (dgd_pkg::reg_e'(cfg_index_i))
        dgd_pkg::REG_DIMENSION: cfg_q.dimension <= cfg_data_i[1:0];
        dgd_pkg::REG_NUM_NODES: cfg_q.num_nodes <= cfg_data_i[2:0];
        dgd_pkg::REG_NUM_VARS:  cfg_q.num_vars  <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  dgd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .component_i   (component_i),
    .var_in_i      (var_in_i),
    .var_out_i     (var_out_i),
    .node_i_i      (node_i_i),
    .node_j_i      (node_j_i),
    .value_i       (value_i),
    .prior_value_i (prior_value_i),
    .deq_valid_o   (deq_valid),
    .deq_ready_i   (deq_ready),
    .deq_cmd_o     (deq_cmd)
  );

  dgd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .deq_valid_i    (deq_valid),
    .deq_ready_o    (deq_ready),
    .deq_cmd_i      (deq_cmd),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_node_i_o   (out_node_i_o),
    .out_node_j_o   (out_node_j_o),
    .out_var_o      (out_var_o),
    .result_value_o (result_value_o),
    .last_o         (last_o)
  );

endmodule
